### design/tcce_pkg.sv
// tcce_pkg: shared types and constants of the client connection engine
// no dependencies
`timescale 1ns / 1ps
package tcce_pkg;

  localparam logic [2:0] CMD_SEG   = 3'd0;
  localparam logic [2:0] CMD_TICK  = 3'd1;
  localparam logic [2:0] CMD_CONN  = 3'd2;
  localparam logic [2:0] CMD_SEND  = 3'd3;
  localparam logic [2:0] CMD_RECV  = 3'd4;
  localparam logic [2:0] CMD_CLOSE = 3'd5;

  localparam logic [4:0] F_FIN = 5'd1;
  localparam logic [4:0] F_SYN = 5'd2;
  localparam logic [4:0] F_RST = 5'd4;
  localparam logic [4:0] F_PSH = 5'd8;
  localparam logic [4:0] F_ACK = 5'd16;

  localparam logic [1:0] PH_CLOSED = 2'd0;
  localparam logic [1:0] PH_SYN    = 2'd1;
  localparam logic [1:0] PH_EST    = 2'd2;
  localparam logic [1:0] PH_FINW   = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_EOS  = 2'd2;

  localparam logic [2:0] REG_LOCAL_IP   = 3'd0;
  localparam logic [2:0] REG_RETX_TICKS = 3'd1;
  localparam logic [2:0] REG_RETRY_LIM  = 3'd2;
  localparam logic [2:0] REG_FINW_TICKS = 3'd3;
  localparam logic [2:0] REG_FIRST_PORT = 3'd4;

  localparam logic [31:0] ISS_MULT = 32'd2654435761;
  localparam logic [15:0] PORT_BASE = 16'd49152;
  localparam logic [5:0]  MIN_HDR = 6'd20;
  localparam int          MAX_RES = 8;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  slot;
    logic [31:0] remote_ip;
    logic [15:0] remote_port;
    logic [15:0] local_port;
    logic [31:0] rx_seq;
    logic [31:0] rx_ack;
    logic [4:0]  rx_flags;
    logic [5:0]  header_bytes;
    logic [15:0] length;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic        is_last;
    logic [2:0]  out_slot;
    logic [1:0]  status;
    logic [4:0]  tx_flags_out;
    logic [31:0] tx_seq_out;
    logic [31:0] tx_ack_out;
    logic [15:0] window_out;
    logic [15:0] src_port_out;
    logic [15:0] dst_port_out;
    logic [31:0] dst_ip_out;
    logic [14:0] count_out;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture input item
    logic start;    // begin event processing
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;
  } dp_sts_t;

endpackage

### design/tcce_if.sv
// tcce_if: valid/ready channel carrying one item
// depends on nothing; payload type set by parameter
`timescale 1ns / 1ps
interface tcce_if #(parameter type item_t = logic) ();
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/tcce_ctrl.sv
// tcce_ctrl: input handshake controller
// depends on tcce_pkg
`timescale 1ns / 1ps
module tcce_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output tcce_pkg::dp_cmd_t cmd,
  input  tcce_pkg::dp_sts_t sts
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_GO   = 3'b010,
    S_RUN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_GO;
      S_GO:   state_nxt = S_RUN;
      S_RUN:  if (!sts.busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cmd.load  = in_ready && in_valid;
  assign cmd.start = (state_r == S_GO);

`ifndef SYNTHESIS
  a_start_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.start) else $error("start did not follow load");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sts.busy |-> !in_ready) else $error("accept while busy");
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
`endif
endmodule

### design/tcce_dp.sv
// tcce_dp: connection table, slot scanner and result queue
// depends on tcce_pkg
`timescale 1ns / 1ps
module tcce_dp #(
  parameter int SLOTS    = 8,
  parameter int RX_BYTES = 16384,
  parameter int TX_BYTES = 2048
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tcce_pkg::in_item_t   in_data,
  input  tcce_pkg::dp_cmd_t    cmd,
  output tcce_pkg::dp_sts_t    sts,
  output tcce_pkg::out_item_t  out_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  logic [31:0]          retx_ticks,
  input  logic [3:0]           retry_limit,
  input  logic [31:0]          finw_ticks,
  input  logic [15:0]          first_port
);
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [16:0] RXB = 17'(RX_BYTES);
  localparam logic [14:0] TXB = 15'(TX_BYTES);

  typedef enum logic [5:0] {
    P_IDLE = 6'b000001,
    P_SCAN = 6'b000010,
    P_EXEC = 6'b000100,
    P_MUL  = 6'b001000,
    P_EMIT = 6'b010000,
    P_DONE = 6'b100000
  } ph_t;

  ph_t ph_r;
  tcce_pkg::in_item_t it_r;
  logic [SW-1:0] idx_r;
  logic [CW-1:0] cnt_r;
  logic          found_r;
  logic [SW-1:0] hit_r;
  logic [31:0]   mul_r;

  // table
  logic [SLOTS-1:0] used_r;
  logic [1:0]  phase_r [SLOTS];
  logic [15:0] lport_r [SLOTS];
  logic [15:0] rport_r [SLOTS];
  logic [31:0] rip_r   [SLOTS];
  logic [31:0] snxt_r  [SLOTS];
  logic [31:0] rnxt_r  [SLOTS];
  logic        pfin_r  [SLOTS];
  logic [16:0] held_r  [SLOTS];
  logic [11:0] plen_r  [SLOTS];
  logic [4:0]  pflg_r  [SLOTS];
  logic [31:0] pseq_r  [SLOTS];
  logic [31:0] ptim_r  [SLOTS];
  logic [3:0]  ptry_r  [SLOTS];
  logic [15:0] port_ctr_r;
  logic [31:0] iss_cnt_r;
  logic [31:0] now_r;

  // result queue, up to eight per item
  tcce_pkg::out_item_t q_r [tcce_pkg::MAX_RES];
  logic [3:0] qw_r, qr_r;

  logic [SW-1:0] cur;
  assign cur = (ph_r == P_SCAN) ? idx_r : hit_r;

  function automatic logic [15:0] win_of(input logic [16:0] h);
    logic [16:0] fr;
    fr = (h >= RXB) ? 17'd0 : RXB - h;
    return fr[16] ? 16'hFFFF : fr[15:0];
  endfunction

  tcce_pkg::out_item_t seg_v, rep_v;
  logic [16:0] dlen;
  logic [16:0] free_c;
  logic [14:0] sendlen;
  logic [14:0] rcvn;
  logic [31:0] age;
  logic        slot_ok;

  always_comb begin
    seg_v = '0;
    seg_v.out_slot     = 3'(cur);
    seg_v.tx_ack_out   = rnxt_r[cur];
    seg_v.window_out   = win_of(held_r[cur]);
    seg_v.src_port_out = lport_r[cur];
    seg_v.dst_port_out = rport_r[cur];
    seg_v.dst_ip_out   = rip_r[cur];
    rep_v = '0;
    rep_v.result_kind = 1'b1;
    rep_v.out_slot = it_r.slot;
    dlen    = {1'b0, it_r.length} - {11'd0, it_r.header_bytes};
    free_c  = (held_r[cur] >= RXB) ? 17'd0 : RXB - held_r[cur];
    sendlen = ({1'b0, it_r.length} > {1'b0, TXB}) ? TXB : it_r.length[14:0];
    rcvn    = (held_r[cur] > {1'b0, it_r.length}) ? it_r.length[14:0]
                                                  : held_r[cur][14:0];
    age     = now_r - ptim_r[cur];
    slot_ok = ({29'd0, it_r.slot} < 32'(SLOTS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= P_IDLE;
      used_r <= '0;
      port_ctr_r <= tcce_pkg::PORT_BASE;
      iss_cnt_r <= 32'd1;
      now_r <= '0;
      qw_r <= '0;
      qr_r <= '0;
      for (int i = 0; i < SLOTS; i++) phase_r[i] <= tcce_pkg::PH_CLOSED;
    end else begin
      if (out_valid && out_ready) qr_r <= qr_r + 4'd1;
      if (cmd.load) it_r <= in_data;
      case (ph_r)
        P_IDLE: if (cmd.start) begin
          qw_r <= '0; qr_r <= '0;
          idx_r <= '0; cnt_r <= '0; found_r <= 1'b0;
          case (it_r.cmd)
            tcce_pkg::CMD_SEG: ph_r <= (it_r.length < 16'd20) ? P_DONE : P_SCAN;
            tcce_pkg::CMD_TICK: begin now_r <= now_r + 32'd1; ph_r <= P_SCAN; end
            tcce_pkg::CMD_CONN: ph_r <= P_SCAN;
            tcce_pkg::CMD_SEND, tcce_pkg::CMD_RECV, tcce_pkg::CMD_CLOSE: begin
              hit_r <= SW'(it_r.slot); ph_r <= P_EXEC;
            end
            default: ph_r <= P_DONE;
          endcase
        end
        P_SCAN: begin
          // one slot a cycle
          if (it_r.cmd == tcce_pkg::CMD_TICK) begin
            if (used_r[idx_r]) begin
              if (pflg_r[idx_r] != 5'd0 && age >= retx_ticks &&
                  qw_r < 4'(tcce_pkg::MAX_RES)) begin
                if (ptry_r[idx_r] >= retry_limit) begin
                  used_r[idx_r] <= 1'b0; phase_r[idx_r] <= tcce_pkg::PH_CLOSED;
                end else begin
                  ptry_r[idx_r] <= ptry_r[idx_r] + 4'd1;
                  q_r[qw_r[2:0]] <= '{result_kind: 1'b0, is_last: 1'b0,
                    out_slot: 3'(idx_r), status: 2'd0, tx_flags_out: pflg_r[idx_r],
                    tx_seq_out: pseq_r[idx_r], tx_ack_out: seg_v.tx_ack_out,
                    window_out: seg_v.window_out, src_port_out: seg_v.src_port_out,
                    dst_port_out: seg_v.dst_port_out, dst_ip_out: seg_v.dst_ip_out,
                    count_out: {3'd0, plen_r[idx_r]}};
                  qw_r <= qw_r + 4'd1;
                  ptim_r[idx_r] <= now_r;
                  // resent record is fresh, finwait age is zero
                end
              end else if (phase_r[idx_r] == tcce_pkg::PH_FINW &&
                           pflg_r[idx_r] == 5'd0 && age > finw_ticks) begin
                used_r[idx_r] <= 1'b0; phase_r[idx_r] <= tcce_pkg::PH_CLOSED;
              end
            end
            if (32'(idx_r) == SLOTS - 1) ph_r <= P_EMIT;
            else idx_r <= idx_r + SW'(1);
          end else begin
            if (!found_r && (it_r.cmd == tcce_pkg::CMD_CONN ? !used_r[idx_r] :
                (used_r[idx_r] && lport_r[idx_r] == it_r.local_port &&
                 rip_r[idx_r] == it_r.remote_ip &&
                 rport_r[idx_r] == it_r.remote_port))) begin
              found_r <= 1'b1; hit_r <= idx_r;
            end
            if (32'(idx_r) == SLOTS - 1) ph_r <= P_EXEC;
            else idx_r <= idx_r + SW'(1);
          end
        end
        P_EXEC: begin
          ph_r <= P_EMIT;
          case (it_r.cmd)
            tcce_pkg::CMD_SEG: begin
              if (!found_r || it_r.header_bytes < tcce_pkg::MIN_HDR ||
                  {10'd0, it_r.header_bytes} > it_r.length) ph_r <= P_DONE;
              else if ((it_r.rx_flags & tcce_pkg::F_RST) != 5'd0) begin
                used_r[cur] <= 1'b0; phase_r[cur] <= tcce_pkg::PH_CLOSED; ph_r <= P_DONE;
              end else if (phase_r[cur] == tcce_pkg::PH_SYN) begin
                if (it_r.rx_flags[1] && it_r.rx_flags[4] && it_r.rx_ack == snxt_r[cur]) begin
                  rnxt_r[cur] <= it_r.rx_seq + 32'd1;
                  plen_r[cur] <= '0; pflg_r[cur] <= '0;
                  phase_r[cur] <= tcce_pkg::PH_EST;
                  q_r[0] <= seg_v; q_r[0].tx_flags_out <= tcce_pkg::F_ACK;
                  q_r[0].tx_seq_out <= snxt_r[cur];
                  q_r[0].tx_ack_out <= it_r.rx_seq + 32'd1;
                  qw_r <= 4'd1;
                end else ph_r <= P_DONE;
              end else begin : est
                logic [31:0] rn;
                logic [16:0] hd;
                logic [3:0]  n;
                rn = rnxt_r[cur]; hd = held_r[cur]; n = 4'd0;
                if (it_r.rx_flags[4] && it_r.rx_ack == snxt_r[cur]) begin
                  plen_r[cur] <= '0; pflg_r[cur] <= '0;
                end
                if (dlen != 17'd0 && phase_r[cur] == tcce_pkg::PH_EST) begin
                  if (it_r.rx_seq == rn && free_c >= dlen) begin
                    hd = hd + dlen; rn = rn + {15'd0, dlen};
                  end
                  q_r[0] <= seg_v; q_r[0].tx_flags_out <= tcce_pkg::F_ACK;
                  q_r[0].tx_seq_out <= snxt_r[cur]; q_r[0].tx_ack_out <= rn;
                  q_r[0].window_out <= win_of(hd);
                  n = 4'd1;
                end
                if (it_r.rx_flags[0] && it_r.rx_seq + {15'd0, dlen} == rn) begin
                  rn = rn + 32'd1;
                  pfin_r[cur] <= 1'b1;
                  q_r[n[2:0]] <= seg_v; q_r[n[2:0]].tx_flags_out <= tcce_pkg::F_ACK;
                  q_r[n[2:0]].tx_seq_out <= snxt_r[cur]; q_r[n[2:0]].tx_ack_out <= rn;
                  q_r[n[2:0]].window_out <= win_of(hd);
                  n = n + 4'd1;
                  if (phase_r[cur] == tcce_pkg::PH_FINW) begin
                    used_r[cur] <= 1'b0; phase_r[cur] <= tcce_pkg::PH_CLOSED;
                  end
                end
                rnxt_r[cur] <= rn; held_r[cur] <= hd; qw_r <= n;
              end
            end
            tcce_pkg::CMD_CONN: begin
              if (!found_r) begin
                q_r[0] <= rep_v; q_r[0].out_slot <= 3'd0;
                q_r[0].status <= tcce_pkg::ST_FAIL; qw_r <= 4'd1;
              end else begin
                mul_r <= now_r * tcce_pkg::ISS_MULT;
                ph_r <= P_MUL;
              end
            end
            tcce_pkg::CMD_SEND: begin
              qw_r <= 4'd1;
              if (!slot_ok || !used_r[cur] || phase_r[cur] != tcce_pkg::PH_EST) begin
                q_r[0] <= rep_v; q_r[0].status <= tcce_pkg::ST_FAIL;
              end else begin
                q_r[0] <= seg_v; q_r[0].tx_flags_out <= tcce_pkg::F_PSH | tcce_pkg::F_ACK;
                q_r[0].tx_seq_out <= snxt_r[cur]; q_r[0].count_out <= sendlen;
                q_r[1] <= rep_v; q_r[1].count_out <= sendlen;
                pflg_r[cur] <= tcce_pkg::F_PSH | tcce_pkg::F_ACK;
                pseq_r[cur] <= snxt_r[cur]; plen_r[cur] <= sendlen[11:0];
                ptim_r[cur] <= now_r; ptry_r[cur] <= '0;
                snxt_r[cur] <= snxt_r[cur] + {17'd0, sendlen};
                qw_r <= 4'd2;
              end
            end
            tcce_pkg::CMD_RECV: begin
              qw_r <= 4'd1;
              q_r[0] <= rep_v;
              if (!slot_ok || !used_r[cur]) q_r[0].status <= tcce_pkg::ST_FAIL;
              else if (held_r[cur] == 17'd0) begin
                if (pfin_r[cur] || phase_r[cur] == tcce_pkg::PH_CLOSED)
                  q_r[0].status <= tcce_pkg::ST_EOS;
              end else begin
                held_r[cur] <= held_r[cur] - {2'd0, rcvn};
                q_r[0].count_out <= rcvn;
              end
            end
            default: begin
              qw_r <= 4'd1;
              q_r[0] <= rep_v;
              if (!slot_ok || !used_r[cur]) q_r[0].status <= tcce_pkg::ST_FAIL;
              else if (phase_r[cur] != tcce_pkg::PH_EST) used_r[cur] <= 1'b0;
              else begin
                q_r[0] <= seg_v; q_r[0].tx_flags_out <= tcce_pkg::F_FIN | tcce_pkg::F_ACK;
                q_r[0].tx_seq_out <= snxt_r[cur];
                q_r[1] <= rep_v;
                pflg_r[cur] <= tcce_pkg::F_FIN | tcce_pkg::F_ACK;
                pseq_r[cur] <= snxt_r[cur]; plen_r[cur] <= '0;
                ptim_r[cur] <= now_r; ptry_r[cur] <= '0;
                snxt_r[cur] <= snxt_r[cur] + 32'd1;
                phase_r[cur] <= tcce_pkg::PH_FINW;
                qw_r <= 4'd2;
              end
            end
          endcase
        end
        P_MUL: begin : conn
          logic [31:0] iss;
          iss = mul_r + iss_cnt_r;
          used_r[cur] <= 1'b1; phase_r[cur] <= tcce_pkg::PH_SYN;
          lport_r[cur] <= port_ctr_r;
          port_ctr_r <= (port_ctr_r == 16'hFFFF) ? first_port : port_ctr_r + 16'd1;
          rip_r[cur] <= it_r.remote_ip; rport_r[cur] <= it_r.remote_port;
          rnxt_r[cur] <= '0; pfin_r[cur] <= 1'b0; held_r[cur] <= '0;
          iss_cnt_r <= iss_cnt_r + 32'd1;
          snxt_r[cur] <= iss + 32'd1;
          pflg_r[cur] <= tcce_pkg::F_SYN; pseq_r[cur] <= iss; plen_r[cur] <= '0;
          ptim_r[cur] <= now_r; ptry_r[cur] <= '0;
          q_r[0] <= '{result_kind: 1'b0, is_last: 1'b0, out_slot: 3'(cur),
            status: 2'd0, tx_flags_out: tcce_pkg::F_SYN, tx_seq_out: iss,
            tx_ack_out: 32'd0, window_out: win_of(17'd0),
            src_port_out: port_ctr_r, dst_port_out: it_r.remote_port,
            dst_ip_out: it_r.remote_ip, count_out: 15'd0};
          q_r[1] <= rep_v; q_r[1].out_slot <= 3'(cur);
          qw_r <= 4'd2;
          ph_r <= P_EMIT;
        end
        P_EMIT: if (qr_r + ((out_valid && out_ready) ? 4'd1 : 4'd0) >= qw_r) ph_r <= P_DONE;
        P_DONE: ph_r <= P_IDLE;
        default: ph_r <= P_IDLE;
      endcase
    end
  end

  assign out_valid = (ph_r == P_EMIT) && (qr_r < qw_r);
  always_comb begin
    out_data = q_r[qr_r[2:0]];
    out_data.is_last = (qr_r + 4'd1 == qw_r);
  end
  assign sts.busy = (ph_r != P_IDLE) || cmd.start;

`ifndef SYNTHESIS
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qr_r <= qw_r && qw_r <= 4'd8) else $error("queue pointers out of range");
  a_out_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ph_r == P_EMIT) else $error("result outside emit");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
`endif
endmodule

### design/tcp_client_connection_engine_core.sv
// tcp_client_connection_engine_core: top level with config registers
// depends on tcce_pkg, tcce_if, tcce_ctrl, tcce_dp
//
//  channel | dir | handshake          | payload
//  in_     | in  | valid/ready        | event item (cmd, slot, header fields)
//  out_    | out | valid/ready        | segment descriptor or reply
//  cfg_    | in  | apb psel/penable   | five registers at 4*i
//
// tick, connect and segment items of 20 bytes or more scan the slot table
// (one slot a cycle), then emit their results; send, receive and close go
// straight to the named slot. output stalls hold the results in the result queue.
// rst_n is synchronous; it clears the slot table valid bits and counters.
`timescale 1ns / 1ps
module tcp_client_connection_engine_core #(
  parameter int SLOTS    = 8,
  parameter int RX_BYTES = 16384,
  parameter int TX_BYTES = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  tcce_if.sink        in_ch,
  tcce_if.source      out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [31:0] local_ip_r;
  logic [15:0] retx_r, finw_r, first_r;
  logic [3:0]  retry_r;
  tcce_pkg::dp_cmd_t cmd;
  tcce_pkg::dp_sts_t sts;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r <= '0; retx_r <= 16'd50; retry_r <= 4'd8;
      finw_r <= 16'd200; first_r <= tcce_pkg::PORT_BASE;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[4:2])
        tcce_pkg::REG_LOCAL_IP:   local_ip_r <= cfg_pwdata;
        tcce_pkg::REG_RETX_TICKS: retx_r <= cfg_pwdata[15:0];
        tcce_pkg::REG_RETRY_LIM:  retry_r <= cfg_pwdata[3:0];
        tcce_pkg::REG_FINW_TICKS: finw_r <= cfg_pwdata[15:0];
        tcce_pkg::REG_FIRST_PORT: first_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      tcce_pkg::REG_LOCAL_IP:   cfg_prdata = local_ip_r;
      tcce_pkg::REG_RETX_TICKS: cfg_prdata = {16'd0, retx_r};
      tcce_pkg::REG_RETRY_LIM:  cfg_prdata = {28'd0, retry_r};
      tcce_pkg::REG_FINW_TICKS: cfg_prdata = {16'd0, finw_r};
      tcce_pkg::REG_FIRST_PORT: cfg_prdata = {16'd0, first_r};
      default: cfg_prdata = '0;
    endcase
  end

  tcce_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .cmd, .sts
  );

  tcce_dp #(.SLOTS(SLOTS), .RX_BYTES(RX_BYTES), .TX_BYTES(TX_BYTES)) u_dp (
    .clk, .rst_n,
    .in_data(in_ch.data), .cmd, .sts,
    .out_data(out_ch.data), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .retx_ticks({16'd0, retx_r}), .retry_limit(retry_r),
    .finw_ticks({16'd0, finw_r}), .first_port(first_r)
  );
endmodule
